// ===== src/u16u8_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder package
// Shared types, constants and the byte selection function.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int QDepth = 2;
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam logic [5:0]  HiSurrTag = 6'b110110;
  localparam logic [5:0]  LoSurrTag = 6'b110111;
  localparam logic [20:0] SuppBase  = 21'h10000;

  // Sequence length minus one.
  typedef enum logic [1:0] {
    LEN_1 = 2'd0,
    LEN_2 = 2'd1,
    LEN_3 = 2'd2,
    LEN_4 = 2'd3
  } seq_len_t;

  typedef struct packed {
    logic [20:0] cp;
    seq_len_t    len;
  } cp_entry_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             empty;
    logic             full;
  } q_status_t;

  // Byte number idx of the UTF-8 sequence for one code point.
  function automatic logic [7:0] byte_at(cp_entry_t e, logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    unique case (e.len)
      LEN_1: b = {1'b0, e.cp[6:0]};
      LEN_2: begin
        case (idx)
          2'd0:    b = {3'b110, e.cp[10:6]};
          default: b = {2'b10, e.cp[5:0]};
        endcase
      end
      LEN_3: begin
        case (idx)
          2'd0:    b = {4'b1110, e.cp[15:12]};
          2'd1:    b = {2'b10, e.cp[11:6]};
          default: b = {2'b10, e.cp[5:0]};
        endcase
      end
      LEN_4: begin
        case (idx)
          2'd0:    b = {5'b11110, e.cp[20:18]};
          2'd1:    b = {2'b10, e.cp[17:12]};
          2'd2:    b = {2'b10, e.cp[11:6]};
          default: b = {2'b10, e.cp[5:0]};
        endcase
      end
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== src/utf16_to_utf8_encoder_core.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder core
// Converts UTF-16 code units into UTF-8 bytes, last byte of each sequence marked.
//
//   Channel  Handshake     Payload
//   input    push / full   code_unit[15:0], start_of_string
//   output   pop / empty   out_byte[7:0], last_byte
//
// The byte serializer emits one byte per cycle while the output is popped, so a word
// gives 1 to 3 bytes (4 for a surrogate pair); a held high surrogate gives no byte.
// A word is written into the queue and its first byte then into the output register.
// A two-entry code point queue lets the front keep accepting while output stalls.
// Synchronous reset empties the queue and the output and clears the held surrogate.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] code_unit,
  input  logic        start_of_string,
  input  logic        pop,
  output logic        empty,
  output logic [7:0]  out_byte,
  output logic        last_byte
);
  import u16u8_pkg::*;

  logic      q_wr;
  logic      q_rd;
  cp_entry_t q_wdata;
  cp_entry_t q_rdata;
  q_status_t q_stat;

  assign full = q_stat.full;

  u16u8_front u_front (
    .clk             (clk),
    .rst             (rst),
    .push            (push),
    .code_unit       (code_unit),
    .start_of_string (start_of_string),
    .q_full          (q_stat.full),
    .q_wr            (q_wr),
    .q_wdata         (q_wdata)
  );

  u16u8_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr     (q_wr),
    .wdata  (q_wdata),
    .rd     (q_rd),
    .rdata  (q_rdata),
    .status (q_stat)
  );

  u16u8_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_rdata   (q_rdata),
    .q_empty   (q_stat.empty),
    .q_rd      (q_rd),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .last_byte (last_byte)
  );

  a_hi_no_write: assert property (@(posedge clk) disable iff (rst)
    (push && !full && code_unit[15:10] == HiSurrTag) |-> !q_wr)
    else $error("high surrogate wrote a code point");

  a_rd_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_rd |-> !q_stat.empty)
    else $error("queue read while empty");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= QCntW'(QDepth))
    else $error("queue count out of range");

  a_write_grows: assert property (@(posedge clk) disable iff (rst)
    (q_wr && !q_stat.full && !q_rd) |=> (q_stat.count == $past(q_stat.count) + 1'b1))
    else $error("queue count did not grow on write");

endmodule

// ===== src/u16u8_front.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder front end
// Accepts code units, pairs surrogates and queues code points with lengths.
// ----------------------------------------------------------------------------
module u16u8_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  logic [15:0]           code_unit,
  input  logic                  start_of_string,
  input  logic                  q_full,
  output logic                  q_wr,
  output u16u8_pkg::cp_entry_t  q_wdata
);
  import u16u8_pkg::*;

  logic       surrogate_pending;
  logic [9:0] high_bits;
  logic       accept;
  logic       is_hi;
  logic       is_lo;
  logic       pair;

  assign accept = push && !q_full;
  assign is_hi  = (code_unit[15:10] == HiSurrTag);
  assign is_lo  = (code_unit[15:10] == LoSurrTag);
  // The start flag drops any held high surrogate before this word is looked at.
  assign pair   = surrogate_pending && !start_of_string && is_lo;

  always_comb begin
    q_wdata.cp  = {5'd0, code_unit};
    q_wdata.len = LEN_3;
    if (pair) begin
      q_wdata.cp  = SuppBase + {1'b0, high_bits, code_unit[9:0]};
      q_wdata.len = LEN_4;
    end else if (code_unit[15:7] == 9'd0) begin
      q_wdata.len = LEN_1;
    end else if (code_unit[15:11] == 5'd0) begin
      q_wdata.len = LEN_2;
    end
  end

  assign q_wr = accept && !is_hi;

  always_ff @(posedge clk) begin
    if (rst) begin
      surrogate_pending <= 1'b0;
      high_bits         <= 10'd0;
    end else if (accept) begin
      if (is_hi) begin
        surrogate_pending <= 1'b1;
        high_bits         <= code_unit[9:0];
      end else begin
        surrogate_pending <= 1'b0;
      end
    end
  end

endmodule

// ===== src/u16u8_queue.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder code point queue
// Short register queue between front end and byte serializer.
// ----------------------------------------------------------------------------
module u16u8_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wr,
  input  u16u8_pkg::cp_entry_t  wdata,
  input  logic                  rd,
  output u16u8_pkg::cp_entry_t  rdata,
  output u16u8_pkg::q_status_t  status
);
  import u16u8_pkg::*;

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  cp_entry_t        mem [QDepth];
  logic [PtrW-1:0]  wptr;
  logic [PtrW-1:0]  rptr;
  logic [QCntW-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign status.count = count;
  assign status.empty = (count == '0);
  assign status.full  = (count == QCntW'(QDepth));
  assign do_wr = wr && !status.full;
  assign do_rd = rd && !status.empty;
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PtrW'(QDepth - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PtrW'(QDepth - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/u16u8_back.sv =====
// ----------------------------------------------------------------------------
// UTF-16 to UTF-8 encoder byte serializer
// Walks the queued code point one byte per cycle, while the output is popped or empty, into an output register.
// ----------------------------------------------------------------------------
module u16u8_back (
  input  logic                  clk,
  input  logic                  rst,
  input  u16u8_pkg::cp_entry_t  q_rdata,
  input  logic                  q_empty,
  output logic                  q_rd,
  input  logic                  pop,
  output logic                  empty,
  output logic [7:0]            out_byte,
  output logic                  last_byte
);
  import u16u8_pkg::*;

  logic       out_valid;
  logic [1:0] idx;
  logic       load;
  logic       at_end;

  assign load   = !q_empty && (!out_valid || pop);
  assign at_end = (idx == q_rdata.len);
  assign q_rd   = load && at_end;
  assign empty  = !out_valid;

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte  <= byte_at(q_rdata, idx);
      last_byte <= at_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= at_end ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
